// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// ===== rtl/vdld_pkg.sv =====
// ---------------------------------------------------------------------------
// vdld_pkg
// Types, opcodes and helpers of the vector display-list decoder.
// ---------------------------------------------------------------------------
package vdld_pkg;

   localparam int BYTE_W  = 8;
   localparam int COORD_W = 15;
   localparam int TDATA_W = 72;

   localparam logic [BYTE_W-1:0] BRIGHT_RESET = 8'h7f;

   localparam logic [BYTE_W-1:0] OP_BRIGHT = 8'd1;
   localparam logic [BYTE_W-1:0] OP_DOT    = 8'd2;
   localparam logic [BYTE_W-1:0] OP_LINE   = 8'd3;
   localparam logic [BYTE_W-1:0] OP_PATH   = 8'd4;
   localparam logic [BYTE_W-1:0] OP_END    = 8'd5;

   localparam logic KIND_SEGMENT = 1'b0;
   localparam logic KIND_END     = 1'b1;

   typedef enum logic [6:0] {
      PH_OPCODE     = 7'b0000001,
      PH_BRIGHT     = 7'b0000010,
      PH_DOT        = 7'b0000100,
      PH_LINE       = 7'b0001000,
      PH_PATH_COUNT = 7'b0010000,
      PH_PATH_FIRST = 7'b0100000,
      PH_PATH_POINT = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic                      emit;
      logic                      kind;
      logic signed [COORD_W-1:0] x_start;
      logic signed [COORD_W-1:0] y_start;
      logic signed [COORD_W-1:0] x_end;
      logic signed [COORD_W-1:0] y_end;
      logic [BYTE_W-1:0]         beam_level;
   } result_type;

   function automatic logic signed [COORD_W-1:0] scale_coord(input logic [BYTE_W-1:0] b);
      return {b, 7'b0000000};
   endfunction

   function automatic result_type make_segment(input logic [BYTE_W-1:0] xs,
                                               input logic [BYTE_W-1:0] ys,
                                               input logic [BYTE_W-1:0] xe,
                                               input logic [BYTE_W-1:0] ye,
                                               input logic [BYTE_W-1:0] level);
      result_type r;
      r.emit       = 1'b1;
      r.kind       = KIND_SEGMENT;
      r.x_start    = scale_coord(xs);
      r.y_start    = scale_coord(ys);
      r.x_end      = scale_coord(xe);
      r.y_end      = scale_coord(ye);
      r.beam_level = level;
      return r;
   endfunction

endpackage

// ===== rtl/vdld_parser.sv =====
// ---------------------------------------------------------------------------
// vdld_parser
// Display-list parser state and the result decoded from the current byte.
// ---------------------------------------------------------------------------
module vdld_parser
   import vdld_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [BYTE_W-1:0] data_byte,
   output result_type        result
);

   phase_type         phase_ff,  phase_in;
   logic [1:0]        index_ff,  index_in;
   logic [BYTE_W-1:0] held_ff [4];
   logic [BYTE_W-1:0] held_in [4];
   logic [BYTE_W-1:0] points_ff, points_in;
   logic [BYTE_W-1:0] bright_ff, bright_in;

   always_comb begin
      logic [BYTE_W-1:0] w [4];
      logic [BYTE_W-1:0] pts_dec;
      w        = held_ff;
      pts_dec  = (points_ff != '0) ? points_ff - 8'd1 : points_ff;
      phase_in  = phase_ff;
      index_in  = index_ff;
      held_in   = held_ff;
      points_in = points_ff;
      bright_in = bright_ff;
      result    = '0;
      case (phase_ff)
         PH_BRIGHT: begin
            bright_in = data_byte;
            phase_in  = PH_OPCODE;
         end
         PH_DOT: begin
            w[index_ff] = data_byte;
            held_in     = w;
            if (index_ff != 2'd0) begin
               result   = make_segment(w[0], w[1], w[0], w[1], bright_ff);
               phase_in = PH_OPCODE;
               index_in = 2'd0;
            end else begin
               index_in = index_ff + 2'd1;
            end
         end
         PH_LINE, PH_PATH_FIRST: begin
            w[index_ff] = data_byte;
            held_in     = w;
            if (index_ff == 2'd3) begin
               result   = make_segment(w[0], w[1], w[2], w[3], bright_ff);
               index_in = 2'd0;
               if (phase_ff == PH_PATH_FIRST && points_ff != '0) begin
                  phase_in = PH_PATH_POINT;
               end else begin
                  phase_in = PH_OPCODE;
               end
            end else begin
               index_in = index_ff + 2'd1;
            end
         end
         PH_PATH_COUNT: begin
            points_in = (data_byte != '0) ? data_byte - 8'd1 : '0;
            index_in  = 2'd0;
            phase_in  = PH_PATH_FIRST;
         end
         PH_PATH_POINT: begin
            w[{1'b0, index_ff[0]}] = data_byte;
            held_in                = w;
            if (index_ff[0]) begin
               result     = make_segment(held_ff[2], held_ff[3], w[0], w[1], bright_ff);
               held_in[2] = w[0];
               held_in[3] = w[1];
               index_in   = 2'd0;
               points_in  = pts_dec;
               if (pts_dec == '0) begin
                  phase_in = PH_OPCODE;
               end
            end else begin
               index_in = 2'd1;
            end
         end
         default: begin
            index_in = 2'd0;
            phase_in = PH_OPCODE;
            case (data_byte)
               OP_BRIGHT: phase_in = PH_BRIGHT;
               OP_DOT:    phase_in = PH_DOT;
               OP_LINE:   phase_in = PH_LINE;
               OP_PATH:   phase_in = PH_PATH_COUNT;
               OP_END: begin
                  result.emit = 1'b1;
                  result.kind = KIND_END;
               end
               default:   phase_in = PH_OPCODE;
            endcase
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_OPCODE;
         index_ff  <= 2'd0;
         held_ff   <= '{default: '0};
         points_ff <= '0;
         bright_ff <= BRIGHT_RESET;
      end else if (step) begin
         phase_ff  <= phase_in;
         index_ff  <= index_in;
         held_ff   <= held_in;
         points_ff <= points_in;
         bright_ff <= bright_in;
      end
   end

endmodule

// ===== rtl/vector_display_list_decoder_core.sv =====
// ---------------------------------------------------------------------------
// vector_display_list_decoder_core
// Turns a display-list byte stream into beam segments and end markers.
// ---------------------------------------------------------------------------
// One byte is taken per cycle, back to back, as long as results are drained.
// A byte is held in the input register, decoded against the parser state
// in a single pass and lands in the result register. Bytes that do not
// complete a command (opcodes other than END, counts, leading coordinates,
// brightness values, unknown opcodes) produce no transaction. A stalled
// result holds the pipe; the input register frees as soon as the result
// register is taken.
module vector_display_list_decoder_core
   import vdld_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [BYTE_W-1:0]  req_tdata,   // [7:0] data_byte
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,   // x_start, y_start, x_end, y_end, beam_level, pad
   output logic               rsp_tuser    // [0] kind
);

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff;
   result_type        result;
   logic              advance;
   logic              step;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign step       = in_valid_ff && advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = advance ? (step && result.emit) : rsp_valid_ff;
   end

   vdld_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (step && result.emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {4'b0000, rsp_ff.beam_level, rsp_ff.y_end, rsp_ff.x_end,
                        rsp_ff.y_start, rsp_ff.x_start};

endmodule

// ===== rtl/vdld_checker.sv =====
// ---------------------------------------------------------------------------
// vdld_checker
// Port-level checks on the display-list decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module vdld_checker
   import vdld_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [BYTE_W-1:0]  req_tdata,
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [TDATA_W-1:0] rsp_tdata,
   input  logic               rsp_tuser
);

   logic req_fire;
   logic req_idle;

   assign req_fire = req_tvalid && req_tready;
   assign req_idle = (req_tdata == req_tdata) && !req_fire;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `ASSERT_IMPLY(a_end_clear, clock, reset, rsp_tvalid && rsp_tuser == KIND_END, rsp_tdata == '0)
   `ASSERT_IMPLY(a_ready_empty, clock, reset, !rsp_tvalid, req_tready)
   `ASSERT_IMPLY(a_rsp_cause, clock, reset, $rose(rsp_tvalid), $past(req_fire, 2) && !$past(req_idle, 2))

endmodule

bind vector_display_list_decoder_core vdld_checker u_vdld_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
